FILE: hdl/stlp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stlp_pkg;

  // Largest graph the block is built for, and the fixed field widths.
  localparam int MaxNodes   = 64;
  localparam int NodeW      = 6;
  localparam int DegW       = 7;
  localparam int CountW     = 11;
  localparam int NodeCountW = 7;
  localparam int CfgDataW   = 64;
  localparam int CfgIdxW    = 1;

  localparam logic [NodeCountW-1:0] NodeCountReset = 7'd64;

  // Commands carried by an input item.
  typedef enum logic [1:0] {
    CmdAdd    = 2'd0,
    CmdRemove = 2'd1,
    CmdPrune  = 2'd2,
    CmdClear  = 2'd3
  } cmd_e;

  // Status codes of a result item.
  typedef enum logic [1:0] {
    StOk  = 2'd0,
    StDup = 2'd1,
    StBad = 2'd2
  } status_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CfgTerminalMask = 1'b0,
    CfgNodeCount    = 1'b1
  } cfg_reg_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    StIdle,
    StRdB,
    StWrB,
    StScan,
    StRow,
    StWrJ
  } state_e;

  // Index of the lowest set bit; the top index when no bit is set.
  function automatic logic [NodeW-1:0] lowest_one(input logic [MaxNodes-1:0] v);
    logic [NodeW-1:0] idx;
    idx = NodeW'(MaxNodes - 1);
    for (int i = MaxNodes - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = NodeW'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/stlp_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module stlp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port and one read port with registered read data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: hdl/steiner_tree_leaf_pruner_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Add and remove pass through StRdB, where a duplicate ends, and StWrB before the registered result strobe;
// clear and a bad edge answer in the cycle after accept. A new item is accepted in the cycle its result is shown.
// Prune emits each edge in three steps (read leaf row, write leaf, write neighbor), then a done item.
// The row memory has one read and one write port, which sets these step sequences.
// Reset and clear empty the graph at once through per-row valid bits; there is no clearing pass.
// The receiver cannot stall: each result strobe lasts exactly one cycle.
module steiner_tree_leaf_pruner_unit #(
  parameter int MAX_NODES = stlp_pkg::MaxNodes
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [1:0]                     cmd_i,
  input  wire logic [stlp_pkg::NodeW-1:0]     node_a_i,
  input  wire logic [stlp_pkg::NodeW-1:0]     node_b_i,
  input  wire logic                           cfg_we_i,
  input  wire logic [stlp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [stlp_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output logic                                result_valid_o,
  output logic [1:0]                          status_o,
  output logic                                edge_valid_o,
  output logic [stlp_pkg::NodeW-1:0]          edge_from_o,
  output logic [stlp_pkg::NodeW-1:0]          edge_to_o,
  output logic [stlp_pkg::CountW-1:0]         edge_total_o,
  output logic                                last_o
);

  localparam int RowW   = MAX_NODES;
  localparam int AddrW  = $clog2(MAX_NODES);
  localparam int DegW   = stlp_pkg::DegW;
  localparam int WordW  = RowW + DegW;
  localparam int NcW    = stlp_pkg::NodeCountW;
  localparam logic [AddrW-1:0] KMax = AddrW'(MAX_NODES - 1);

  // Configuration registers.
  logic [RowW-1:0] term_q;
  logic [NcW-1:0]  node_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_q       <= '0;
      node_count_q <= stlp_pkg::NodeCountReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == stlp_pkg::CfgTerminalMask) begin
        term_q <= cfg_wdata_i[RowW-1:0];
      end else begin
        node_count_q <= cfg_wdata_i[NcW-1:0];
      end
    end
  end

  // Nodes in use, limited to the built size, and the mask of scanned nodes.
  logic [NcW-1:0]  n_eff;
  logic [RowW-1:0] below_n;

  always_comb begin
    n_eff = (node_count_q > NcW'(MAX_NODES)) ? NcW'(MAX_NODES) : node_count_q;
    for (int n = 0; n < RowW; n++) begin
      below_n[n] = (NcW'(n) < n_eff);
    end
  end

  // Sequencer and working registers.
  stlp_pkg::state_e state_q, state_d;
  logic [AddrW-1:0] a_q, a_d, b_q, b_d, i_q, i_d, j_q, j_d, k_q, k_d;
  logic add_q, add_d;
  logic [stlp_pkg::CountW-1:0] cnt_q, cnt_d;

  // Row memory: each word holds a node's degree above its adjacency row.
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [WordW-1:0] ram_wdata, ram_rdata;

  stlp_ram #(
    .WIDTH(WordW),
    .DEPTH(MAX_NODES)
  ) u_rows (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // A row never written since reset or clear reads as empty.
  logic [RowW-1:0] row_valid_q, leaf_q;
  logic            rd_valid_q;
  logic            clr;
  logic [WordW-1:0] rd_word;
  logic [RowW-1:0]  rd_row;
  logic [DegW-1:0]  rd_deg;
  logic [DegW-1:0]  wr_deg;

  assign rd_word = rd_valid_q ? ram_rdata : '0;
  assign rd_row  = rd_word[RowW-1:0];
  assign rd_deg  = rd_word[RowW +: DegW];
  assign wr_deg  = ram_wdata[RowW +: DegW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      leaf_q      <= '0;
      rd_valid_q  <= 1'b0;
    end else begin
      rd_valid_q <= row_valid_q[ram_raddr];
      if (clr) begin
        row_valid_q <= '0;
        leaf_q      <= '0;
      end else if (ram_we) begin
        row_valid_q[ram_waddr] <= 1'b1;
        leaf_q[ram_waddr]      <= (wr_deg == DegW'(1));
      end
    end
  end

  // Prune candidates and the lowest set bits used by the walk.
  logic [RowW-1:0]              cand;
  logic [stlp_pkg::NodeW-1:0]   cand_low, row_low;
  logic [AddrW-1:0]             cand_idx, row_idx;
  logic                         bad_edge;

  assign cand     = leaf_q & ~term_q & below_n;
  assign cand_low = stlp_pkg::lowest_one(stlp_pkg::MaxNodes'(cand));
  assign row_low  = stlp_pkg::lowest_one(stlp_pkg::MaxNodes'(rd_row));
  assign cand_idx = cand_low[AddrW-1:0];
  assign row_idx  = row_low[AddrW-1:0];
  assign bad_edge = ({1'b0, node_a_i} >= n_eff) || ({1'b0, node_b_i} >= n_eff) ||
                    (node_a_i == node_b_i);

  // Result register contents.
  logic                       res_valid_q, res_valid_d;
  stlp_pkg::status_e          res_status_q, res_status_d;
  logic                       res_edge_q, res_edge_d;
  logic [stlp_pkg::NodeW-1:0] res_from_q, res_from_d, res_to_q, res_to_d;
  logic                       res_last_q, res_last_d;

  // Next state, memory accesses and result items.
  always_comb begin
    state_d      = state_q;
    a_d          = a_q;
    b_d          = b_q;
    i_d          = i_q;
    j_d          = j_q;
    k_d          = k_q;
    add_d        = add_q;
    cnt_d        = cnt_q;
    clr          = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = a_q;
    ram_wdata    = '0;
    ram_raddr    = a_q;
    res_valid_d  = 1'b0;
    res_status_d = stlp_pkg::StOk;
    res_edge_d   = 1'b0;
    res_from_d   = '0;
    res_to_d     = '0;
    res_last_d   = 1'b1;

    unique case (state_q)
      stlp_pkg::StIdle: begin
        ram_raddr = node_a_i[AddrW-1:0];
        if (start) begin
          unique case (stlp_pkg::cmd_e'(cmd_i))
            stlp_pkg::CmdClear: begin
              clr         = 1'b1;
              cnt_d       = '0;
              res_valid_d = 1'b1;
            end
            stlp_pkg::CmdPrune: begin
              k_d     = '0;
              state_d = stlp_pkg::StScan;
            end
            stlp_pkg::CmdAdd, stlp_pkg::CmdRemove: begin
              if (bad_edge) begin
                res_valid_d  = 1'b1;
                res_status_d = stlp_pkg::StBad;
              end else begin
                a_d     = node_a_i[AddrW-1:0];
                b_d     = node_b_i[AddrW-1:0];
                add_d   = (stlp_pkg::cmd_e'(cmd_i) == stlp_pkg::CmdAdd);
                state_d = stlp_pkg::StRdB;
              end
            end
          endcase
        end
      end

      // Row a is here: decide, update row a and fetch row b.
      stlp_pkg::StRdB: begin
        ram_raddr = b_q;
        if (add_q == rd_row[b_q]) begin
          res_valid_d  = 1'b1;
          res_status_d = stlp_pkg::StDup;
          state_d      = stlp_pkg::StIdle;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = a_q;
          ram_wdata = add_q ? {rd_deg + DegW'(1), rd_row | (RowW'(1) << b_q)}
                            : {rd_deg - DegW'(1), rd_row & ~(RowW'(1) << b_q)};
          state_d   = stlp_pkg::StWrB;
        end
      end

      // Row b is here: update it and report the item.
      stlp_pkg::StWrB: begin
        ram_we      = 1'b1;
        ram_waddr   = b_q;
        ram_wdata   = add_q ? {rd_deg + DegW'(1), rd_row | (RowW'(1) << a_q)}
                            : {rd_deg - DegW'(1), rd_row & ~(RowW'(1) << a_q)};
        cnt_d       = add_q ? cnt_q + 1'b1 : cnt_q - 1'b1;
        res_valid_d = 1'b1;
        state_d     = stlp_pkg::StIdle;
      end

      // Pick the lowest prunable leaf, or finish with the done item.
      stlp_pkg::StScan: begin
        if ((cand == '0) || (k_q == KMax)) begin
          res_valid_d = 1'b1;
          state_d     = stlp_pkg::StIdle;
        end else begin
          i_d       = cand_idx;
          ram_raddr = cand_idx;
          state_d   = stlp_pkg::StRow;
        end
      end

      // Leaf row is here: its one neighbor is j; empty the leaf and fetch row j.
      stlp_pkg::StRow: begin
        j_d       = row_idx;
        ram_raddr = row_idx;
        ram_we    = 1'b1;
        ram_waddr = i_q;
        ram_wdata = {rd_deg - DegW'(1), rd_row & ~(RowW'(1) << row_idx)};
        state_d   = stlp_pkg::StWrJ;
      end

      // Neighbor row is here: drop the leaf from it and report the edge.
      stlp_pkg::StWrJ: begin
        ram_we      = 1'b1;
        ram_waddr   = j_q;
        ram_wdata   = {rd_deg - DegW'(1), rd_row & ~(RowW'(1) << i_q)};
        cnt_d       = cnt_q - 1'b1;
        k_d         = k_q + 1'b1;
        res_valid_d = 1'b1;
        res_edge_d  = 1'b1;
        res_from_d  = stlp_pkg::NodeW'(i_q);
        res_to_d    = stlp_pkg::NodeW'(j_q);
        res_last_d  = 1'b0;
        state_d     = stlp_pkg::StScan;
      end

      default: begin
        state_d = stlp_pkg::StIdle;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= stlp_pkg::StIdle;
      cnt_q       <= '0;
      k_q         <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      k_q         <= k_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    a_q          <= a_d;
    b_q          <= b_d;
    i_q          <= i_d;
    j_q          <= j_d;
    add_q        <= add_d;
    res_status_q <= res_status_d;
    res_edge_q   <= res_edge_d;
    res_from_q   <= res_from_d;
    res_to_q     <= res_to_d;
    res_last_q   <= res_last_d;
  end

  assign busy           = (state_q != stlp_pkg::StIdle);
  assign result_valid_o = res_valid_q;
  assign status_o       = res_status_q;
  assign edge_valid_o   = res_edge_q;
  assign edge_from_o    = res_from_q;
  assign edge_to_o      = res_to_q;
  assign edge_total_o   = cnt_q;
  assign last_o         = res_last_q;

  // A pruned edge item is never the final item of a command.
  a_edge_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_edge_q) |-> !res_last_q)
    else $error("pruned edge item marked last");

  // A clear answers in the next cycle with an empty graph.
  a_clear_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (cmd_i == stlp_pkg::CmdClear)) |=>
      (result_valid_o && (edge_total_o == '0)))
    else $error("clear did not report an empty graph");

  // Leaf flags only exist on rows that hold data.
  a_leaf_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((leaf_q & ~row_valid_q) == '0))
    else $error("leaf flag on an empty row");

  // In the StRdB and StRow states, a write and a read never touch the same row.
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ((state_q == stlp_pkg::StRdB) || (state_q == stlp_pkg::StRow)))
      |-> (ram_waddr != ram_raddr))
    else $error("row read and write collide");

endmodule

`default_nettype wire

FILE: tb/sv/tb_steiner_tree_leaf_pruner_checker.sv
`timescale 1ns / 1ps

// Watches the command, configuration and result ports of the leaf pruner.
// It keeps its own copy of the graph, works out the result items of every
// accepted item, and compares each result strobe with the oldest one waiting.
module tb_steiner_tree_leaf_pruner_checker
  import stlp_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic                 busy_i,
  input  wire logic [1:0]           cmd_i,
  input  wire logic [NodeW-1:0]     node_a_i,
  input  wire logic [NodeW-1:0]     node_b_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [CfgDataW-1:0]  cfg_wdata_i,
  input  wire logic                 result_valid_i,
  input  wire logic [1:0]           status_i,
  input  wire logic                 edge_valid_i,
  input  wire logic [NodeW-1:0]     edge_from_i,
  input  wire logic [NodeW-1:0]     edge_to_i,
  input  wire logic [CountW-1:0]    edge_total_i,
  input  wire logic                 last_i,
  output int                        fail_count_o,
  output int                        pending_o,
  output int                        results_o,
  output int                        pruned_o
);

  typedef struct packed {
    logic [1:0]        status;
    logic              edge_valid;
    logic [NodeW-1:0]  from_node;
    logic [NodeW-1:0]  to_node;
    logic [CountW-1:0] total;
    logic              is_last;
  } graph_answer_t;

  // Shadow copy of the graph and of the two registers.
  logic [MaxNodes-1:0]   adj_row [MaxNodes];
  logic [DegW-1:0]       node_deg [MaxNodes];
  logic [CountW-1:0]     edge_cnt;
  logic [MaxNodes-1:0]   term_mask;
  logic [NodeCountW-1:0] node_cnt;

  graph_answer_t graph_answers_q [$];

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d (result item %0d)",
             $time, field, got, want, results_o);
    fail_count_o++;
  endtask

  task automatic push_answer(input status_e st, input logic ev, input int from_n,
                             input int to_n, input logic lst);
    graph_answer_t r;
    r.status     = st;
    r.edge_valid = ev;
    r.from_node  = NodeW'(from_n);
    r.to_node    = NodeW'(to_n);
    r.total      = edge_cnt;
    r.is_last    = lst;
    graph_answers_q = {graph_answers_q, r};
  endtask

  task automatic cut_edge(input int u, input int v);
    adj_row[u][v] = 1'b0;
    adj_row[v][u] = 1'b0;
    node_deg[u]   = node_deg[u] - 1'b1;
    node_deg[v]   = node_deg[v] - 1'b1;
    edge_cnt      = edge_cnt - 1'b1;
  endtask

  task automatic clear_graph;
    for (int i = 0; i < MaxNodes; i++) begin
      adj_row[i]  = '0;
      node_deg[i] = '0;
    end
    edge_cnt = '0;
  endtask

  // Updates the shadow graph for one item and queues the result items it causes.
  task automatic apply_graph_cmd(input cmd_e c, input int a, input int b);
    int  n;
    int  leaf;
    int  nbr;
    int  k;
    bit  more;
    n = (node_cnt > NodeCountW'(MaxNodes)) ? MaxNodes : int'(node_cnt);
    if (c == CmdClear) begin
      clear_graph();
      push_answer(StOk, 1'b0, 0, 0, 1'b1);
    end else if (c == CmdPrune) begin
      k    = 0;
      more = 1'b1;
      while (more && k < MaxNodes - 1) begin
        // Lowest non-terminal leaf among the scanned nodes.
        leaf = -1;
        for (int i = n - 1; i >= 0; i--) begin
          if (node_deg[i] == DegW'(1) && !term_mask[i]) begin
            leaf = i;
          end
        end
        if (leaf < 0) begin
          more = 1'b0;
        end else begin
          nbr = MaxNodes - 1;
          for (int j = MaxNodes - 2; j >= 0; j--) begin
            if (adj_row[leaf][j]) begin
              nbr = j;
            end
          end
          cut_edge(leaf, nbr);
          push_answer(StOk, 1'b1, leaf, nbr, 1'b0);
          k++;
        end
      end
      push_answer(StOk, 1'b0, 0, 0, 1'b1);
    end else if (a >= n || b >= n || a == b) begin
      push_answer(StBad, 1'b0, 0, 0, 1'b1);
    end else if (c == CmdAdd) begin
      if (adj_row[a][b]) begin
        push_answer(StDup, 1'b0, 0, 0, 1'b1);
      end else begin
        adj_row[a][b] = 1'b1;
        adj_row[b][a] = 1'b1;
        node_deg[a]   = node_deg[a] + 1'b1;
        node_deg[b]   = node_deg[b] + 1'b1;
        edge_cnt      = edge_cnt + 1'b1;
        push_answer(StOk, 1'b0, 0, 0, 1'b1);
      end
    end else begin
      if (adj_row[a][b]) begin
        cut_edge(a, b);
        push_answer(StOk, 1'b0, 0, 0, 1'b1);
      end else begin
        push_answer(StDup, 1'b0, 0, 0, 1'b1);
      end
    end
  endtask

  // Prediction on accept, comparison on each strobe, then register writes.
  always @(posedge clk_i or negedge rst_ni) begin
    graph_answer_t want;
    if (!rst_ni) begin
      clear_graph();
      term_mask = '0;
      node_cnt  = NodeCountReset;
      graph_answers_q.delete();
      fail_count_o = 0;
      results_o    = 0;
      pruned_o     = 0;
      pending_o   <= 0;
    end else begin
      if (start_i && !busy_i) begin
        apply_graph_cmd(cmd_e'(cmd_i), int'(node_a_i), int'(node_b_i));
      end
      if (result_valid_i) begin
        if (graph_answers_q.size() == 0) begin
          report_mismatch("result strobe with nothing awaited", 1, 0);
        end else begin
          want = graph_answers_q.pop_front();
          if (status_i !== want.status) begin
            report_mismatch("status", status_i, want.status);
          end
          if (edge_valid_i !== want.edge_valid) begin
            report_mismatch("edge_valid", edge_valid_i, want.edge_valid);
          end
          if (edge_from_i !== want.from_node) begin
            report_mismatch("edge_from", edge_from_i, want.from_node);
          end
          if (edge_to_i !== want.to_node) begin
            report_mismatch("edge_to", edge_to_i, want.to_node);
          end
          if (edge_total_i !== want.total) begin
            report_mismatch("edge_total", edge_total_i, want.total);
          end
          if (last_i !== want.is_last) begin
            report_mismatch("last", last_i, want.is_last);
          end
        end
        results_o++;
        if (edge_valid_i) begin
          pruned_o++;
        end
      end
      if (cfg_we_i) begin
        if (cfg_reg_e'(cfg_idx_i) == CfgTerminalMask) begin
          term_mask = cfg_wdata_i[MaxNodes-1:0];
        end else begin
          node_cnt = cfg_wdata_i[NodeCountW-1:0];
        end
      end
      pending_o <= graph_answers_q.size();
    end
  end

endmodule

FILE: tb/sv/tb_steiner_tree_leaf_pruner_unit.sv
`timescale 1ns / 1ps

module tb_steiner_tree_leaf_pruner_unit;
  import stlp_pkg::*;

  localparam int CycleLimit = 600000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [1:0]           cmd_i = CmdAdd;
  logic [NodeW-1:0]     node_a_i = '0;
  logic [NodeW-1:0]     node_b_i = '0;
  logic                 cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i = CfgTerminalMask;
  logic [CfgDataW-1:0]  cfg_wdata_i = '0;
  logic                 result_valid_o;
  logic [1:0]           status_o;
  logic                 edge_valid_o;
  logic [NodeW-1:0]     edge_from_o;
  logic [NodeW-1:0]     edge_to_o;
  logic [CountW-1:0]    edge_total_o;
  logic                 last_o;

  int fail_count;
  int pending;
  int results_seen;
  int pruned_seen;
  int items_sent = 0;
  int prunes_sent = 0;
  int settings_used = 0;
  int cycle_cnt = 0;
  bit gaps_on = 1'b1;

  // Clock, 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  steiner_tree_leaf_pruner_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .node_a_i       (node_a_i),
    .node_b_i       (node_b_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .edge_valid_o   (edge_valid_o),
    .edge_from_o    (edge_from_o),
    .edge_to_o      (edge_to_o),
    .edge_total_o   (edge_total_o),
    .last_o         (last_o)
  );

  tb_steiner_tree_leaf_pruner_checker leaf_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .cmd_i          (cmd_i),
    .node_a_i       (node_a_i),
    .node_b_i       (node_b_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_i (result_valid_o),
    .status_i       (status_o),
    .edge_valid_i   (edge_valid_o),
    .edge_from_i    (edge_from_o),
    .edge_to_i      (edge_to_o),
    .edge_total_i   (edge_total_o),
    .last_i         (last_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .results_o      (results_seen),
    .pruned_o       (pruned_seen)
  );

  // Hard stop if the block hangs or stops answering.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Timed out after %0d cycles with %0d result items awaited.",
               cycle_cnt, pending);
      $display("tb_steiner_tree_leaf_pruner_unit NOT OK");
      $finish;
    end
  end

  // Offers one item and returns at the edge that accepts it, start left high.
  task automatic send_item(input cmd_e c, input int a, input int b);
    if (gaps_on && $urandom_range(99) < 36) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start    <= 1'b1;
    cmd_i    <= c;
    node_a_i <= NodeW'(a);
    node_b_i <= NodeW'(b);
    do @(posedge clk_i); while (busy);
    items_sent++;
    if (c == CmdPrune) begin
      prunes_sent++;
    end
  endtask

  // Stops issuing and waits until every awaited result item has arrived.
  task automatic drain;
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0 || busy);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin : stimulus
    int perm [MaxNodes];
    int n_eff;
    int nc;
    int budget;
    int phase_start;
    int tree_size;
    int u;
    int v;
    int tmp;
    int j;
    logic [CfgDataW-1:0] mask;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: eight nodes, node 1 kept as a terminal.
    write_reg(CfgNodeCount, 64'd8);
    write_reg(CfgTerminalMask, 64'h2);
    settings_used++;
    send_item(CmdPrune, 0, 0);          // empty graph, done only
    send_item(CmdAdd, 0, 7);
    send_item(CmdAdd, 7, 0);            // duplicate
    send_item(CmdAdd, 0, 0);            // self-loop
    send_item(CmdAdd, 8, 1);            // first endpoint out of range
    send_item(CmdAdd, 1, 63);           // second endpoint out of range
    send_item(CmdRemove, 2, 3);         // absent edge
    send_item(CmdRemove, 0, 7);
    send_item(CmdRemove, 63, 63);
    send_item(CmdAdd, 0, 1);
    send_item(CmdAdd, 1, 2);
    send_item(CmdAdd, 2, 3);
    send_item(CmdAdd, 3, 4);
    send_item(CmdAdd, 5, 1);
    send_item(CmdPrune, 63, 63);        // chain folds back onto the terminal
    send_item(CmdClear, 0, 0);
    send_item(CmdAdd, 2, 5);
    send_item(CmdAdd, 6, 4);
    send_item(CmdPrune, 0, 0);
    send_item(CmdClear, 63, 63);
    drain();

    // A count above the maximum acts as the maximum.
    write_reg(CfgNodeCount, 64'd127);
    write_reg(CfgTerminalMask, 64'h0);
    settings_used++;
    send_item(CmdAdd, 63, 0);
    send_item(CmdAdd, 5, 40);
    drain();

    // Edges above a lowered count are still reached through scanned leaves.
    write_reg(CfgNodeCount, 64'd10);
    settings_used++;
    send_item(CmdPrune, 0, 0);
    drain();

    // Counts of zero and one reject every edge.
    write_reg(CfgNodeCount, 64'd0);
    settings_used++;
    send_item(CmdAdd, 0, 1);
    drain();
    write_reg(CfgNodeCount, 64'd1);
    settings_used++;
    send_item(CmdRemove, 1, 0);
    drain();

    // Random phases, each under its own node count and terminal mask.
    for (int p = 0; p < 9; p++) begin
      case (p)
        0: begin nc = 8;   mask = 64'h1 << $urandom_range(7); end
        1: begin nc = 2;   mask = '0; end
        2: begin nc = 64;  mask = '0; end
        3: begin nc = 127; mask = {$urandom, $urandom} & {$urandom, $urandom}; end
        4: begin nc = 16;  mask = '1; end
        5: begin nc = 0;   mask = {$urandom, $urandom}; end
        6: begin nc = 1;   mask = {$urandom, $urandom}; end
        7: begin nc = 40;  mask = {$urandom, $urandom} & {$urandom, $urandom}; end
        default: begin nc = 12; mask = {$urandom, $urandom} & {$urandom, $urandom}; end
      endcase
      write_reg(CfgNodeCount, CfgDataW'(nc));
      write_reg(CfgTerminalMask, mask);
      settings_used++;
      n_eff  = (nc > MaxNodes) ? MaxNodes : nc;
      budget = (nc < 2) ? 20 : 60;
      gaps_on = (p != 2);
      phase_start = items_sent;

      // Full path over every node: the longest prune the block can produce.
      if (p == 2) begin
        send_item(CmdClear, $urandom_range(63), $urandom_range(63));
        for (int t = 1; t < MaxNodes; t++) begin
          send_item(CmdAdd, t - 1, t);
        end
        send_item(CmdPrune, $urandom_range(63), $urandom_range(63));
      end

      while (items_sent - phase_start < budget) begin
        if (n_eff >= 2 && $urandom_range(99) < 70) begin
          // Random tree on a random subset of nodes, then prune it.
          if ($urandom_range(9) == 0) begin
            tree_size = n_eff;
          end else begin
            tree_size = $urandom_range(2, (n_eff < 10) ? n_eff : 10);
          end
          for (int i = 0; i < n_eff; i++) begin
            perm[i] = i;
          end
          for (int i = n_eff - 1; i > 0; i--) begin
            j       = $urandom_range(i);
            tmp     = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
          end
          for (int t = 1; t < tree_size; t++) begin
            u = perm[t];
            v = perm[$urandom_range(t - 1)];
            if ($urandom_range(1)) begin
              send_item(CmdAdd, u, v);
            end else begin
              send_item(CmdAdd, v, u);
            end
            if ($urandom_range(9) == 0) begin
              send_item($urandom_range(1) ? CmdAdd : CmdRemove, v, u);
            end
          end
          if ($urandom_range(3) == 0) begin
            send_item(CmdAdd, perm[$urandom_range(tree_size - 1)],
                      perm[$urandom_range(tree_size - 1)]);
          end
          send_item(CmdPrune, $urandom_range(63), $urandom_range(63));
          if ($urandom_range(1)) begin
            send_item(CmdClear, $urandom_range(63), $urandom_range(63));
          end
        end else begin
          // Noise: any command with any endpoints.
          send_item(cmd_e'($urandom_range(3)), $urandom_range(63), $urandom_range(63));
        end
      end
      drain();
    end

    repeat (16) @(posedge clk_i);
    $display("Sent %0d items (%0d prunes) under %0d register settings.",
             items_sent, prunes_sent, settings_used);
    $display("Checked %0d result items, %0d of them pruned edges.",
             results_seen, pruned_seen);
    if (fail_count == 0) begin
      $display("tb_steiner_tree_leaf_pruner_unit OK");
    end else begin
      $display("tb_steiner_tree_leaf_pruner_unit NOT OK");
    end
    $finish;
  end

endmodule
